// File: rtl/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg: shared types and constants for the maze backtracker
// Widths, LFSR polynomial, direction and back-pointer codes.
// ----------------------------------------------------------------------------
package gmb_pkg;

  localparam int MAX_WIDTH_DEF  = 63;
  localparam int MAX_HEIGHT_DEF = 63;

  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [3:0]  ALL_DIRS  = 4'hF;

  localparam logic [2:0] BACK_NONE  = 3'd0;
  localparam logic [2:0] BACK_RIGHT = 3'd1;
  localparam logic [2:0] BACK_DOWN  = 3'd2;
  localparam logic [2:0] BACK_LEFT  = 3'd3;
  localparam logic [2:0] BACK_UP    = 3'd4;
  localparam logic [2:0] BACK_START = 3'd5;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // One LFSR step (Galois, shifting right)
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    lfsr_step = s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
  endfunction

  // Force odd, clamp to [3, cap]
  function automatic logic [5:0] fix_dim(input logic [5:0] v, input logic [5:0] cap);
    logic [5:0] o;
    o = v | 6'd1;
    if (o < 6'd3) o = 6'd3;
    if (o > cap) o = cap;
    fix_dim = o;
  endfunction

endpackage

// File: rtl/grid_maze_backtracker_unit.sv
// ----------------------------------------------------------------------------
// grid_maze_backtracker_unit: randomized depth-first maze generator
// One seed in, one transaction per maze row out.
// ----------------------------------------------------------------------------
// A request runs in three phases, all on one sequencer and one LFSR. Init
// visits every cell of the w x h grid once (column by column), taking one
// draw per cell and writing the row bitmap and node tables. Carving reads
// the node on each visit, then draws a direction, checks the neighbor and
// carves the wall to it, or takes a backtrack step once no direction is left.
// Emission reads each row and holds it until row_ready takes it; seed is not
// ready until the last row has been taken.
module grid_maze_backtracker_unit #(
  parameter int MAX_WIDTH  = gmb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gmb_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        seed_valid,
  output logic        seed_ready,
  input  logic [31:0] seed,
  output logic        row_valid,
  input  logic        row_ready,
  output logic [5:0]  row_index,
  output logic [62:0] row_cells,
  output logic        last_row
);

  localparam logic [5:0] WCAP = 6'(((MAX_WIDTH - 1) | 1) & 63);
  localparam logic [5:0] HCAP = 6'(((MAX_HEIGHT - 1) | 1) & 63);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT_RD, S_INIT_WR, S_NODE_RD, S_NODE_WAIT, S_DRAW,
    S_CHK_RD, S_CHK_WAIT, S_CHK, S_CARVE_ROW, S_CARVE_WR, S_BACK,
    S_OUT_RD, S_OUT_WAIT, S_OUT
  } state_t;

  state_t      state;
  logic [5:0]  maze_width, maze_height;
  logic [15:0] open_threshold;
  logic [5:0]  w, h, cx, cy, nx, ny, ix, iy;
  logic [31:0] random_state;
  logic [3:0]  dirs;
  logic [2:0]  back;
  logic [1:0]  dsel;

  // row memory: one 63-bit word per row
  logic        row_we;
  logic [5:0]  row_addr;
  logic [62:0] row_wdata, row_rdata;
  // node memory: {dirs, back}
  logic        nd_we;
  logic [9:0]  nd_addr;
  logic [6:0]  nd_wdata, nd_rdata;

  gmb_ram #(.WIDTH(63), .DEPTH(64)) u_rows (
    .clk(clk), .we(row_we), .addr(row_addr), .wdata(row_wdata), .rdata(row_rdata));
  gmb_ram #(.WIDTH(7), .DEPTH(1024)) u_nodes (
    .clk(clk), .we(nd_we), .addr(nd_addr), .wdata(nd_wdata), .rdata(nd_rdata));

  function automatic logic [9:0] nidx(input logic [5:0] x, input logic [5:0] y);
    nidx = {y[5:1], x[5:1]};
  endfunction

  logic [31:0] lfsr_nx;
  assign lfsr_nx = gmb_pkg::lfsr_step(random_state);

  // wall cell between the current node and the candidate
  logic [6:0] sum_x, sum_y;
  logic [5:0] mid_x, mid_y;
  assign sum_x = 7'(cx) + 7'(nx);
  assign sum_y = 7'(cy) + 7'(ny);
  assign mid_x = sum_x[6:1];
  assign mid_y = sum_y[6:1];

  logic        init_open, wall_ok;
  logic [62:0] cell_bit;
  assign cell_bit = 63'(1) << ix;
  assign wall_ok = (ix != 6'd0) && (iy != 6'd0) && (ix != w - 6'd1) && (iy != h - 6'd1)
                 && !(ix == 6'd1 && iy == 6'd1) && !(ix == w - 6'd2 && iy == h - 6'd2);
  assign init_open = (ix[0] & iy[0]) | ((lfsr_nx[15:0] < open_threshold) & wall_ok);

  // memory address and write mux
  always_comb begin
    row_we = 1'b0; row_addr = iy; row_wdata = row_rdata;
    nd_we = 1'b0; nd_addr = nidx(cx, cy); nd_wdata = {dirs, back};
    unique case (state)
      S_INIT_RD: row_addr = iy;
      S_INIT_WR: begin
        row_we = 1'b1;
        row_wdata = (ix == 6'd0) ? (init_open ? cell_bit : '0)
                                 : (init_open ? (row_rdata | cell_bit) : row_rdata);
        nd_addr = nidx(ix, iy);
        nd_we = ix[0] & iy[0];
        nd_wdata = {gmb_pkg::ALL_DIRS,
                    (ix == 6'd1 && iy == 6'd1) ? gmb_pkg::BACK_START : gmb_pkg::BACK_NONE};
      end
      S_DRAW: begin
        nd_we = 1'b1;
      end
      S_CHK_RD, S_CHK_WAIT: begin
        row_addr = ny; nd_addr = nidx(nx, ny);
      end
      S_CHK: row_addr = mid_y;
      S_CARVE_ROW: begin
        // store the parent's remaining directions before moving on
        row_addr = mid_y;
        nd_we = 1'b1;
      end
      S_CARVE_WR: begin
        row_addr = mid_y;
        row_we = 1'b1;
        row_wdata = row_rdata | (63'(1) << mid_x);
        nd_addr = nidx(nx, ny);
        nd_we = 1'b1;
        nd_wdata = {gmb_pkg::ALL_DIRS, 3'(((dsel + 2'd2) & 2'd3)) + 3'd1};
      end
      S_OUT_RD, S_OUT_WAIT, S_OUT: row_addr = iy;
      default: ;
    endcase
  end

  assign seed_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      maze_width <= 6'd63; maze_height <= 6'd63; open_threshold <= '0;
      row_valid <= 1'b0;
      random_state <= 32'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gmb_pkg::REG_WIDTH:     maze_width <= cfg_data[5:0];
          gmb_pkg::REG_HEIGHT:    maze_height <= cfg_data[5:0];
          gmb_pkg::REG_THRESHOLD: open_threshold <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (seed_valid) begin
          random_state <= (seed == 32'd0) ? 32'd1 : seed;
          w <= gmb_pkg::fix_dim(maze_width, WCAP);
          h <= gmb_pkg::fix_dim(maze_height, HCAP);
          ix <= '0; iy <= '0;
          state <= S_INIT_RD;
        end
        S_INIT_RD: state <= S_INIT_WR;
        S_INIT_WR: begin
          random_state <= lfsr_nx;
          if (iy == h - 6'd1) begin
            iy <= '0;
            if (ix == w - 6'd1) begin
              cx <= 6'd1; cy <= 6'd1;
              state <= S_NODE_RD;
            end else begin
              ix <= ix + 6'd1;
              state <= S_INIT_RD;
            end
          end else begin
            iy <= iy + 6'd1;
            state <= S_INIT_RD;
          end
        end
        S_NODE_RD: state <= S_NODE_WAIT;
        S_NODE_WAIT: begin
          dirs <= nd_rdata[6:3]; back <= nd_rdata[2:0];
          state <= (nd_rdata[6:3] == 4'd0) ? S_BACK : S_DRAW;
        end
        S_DRAW: begin
          // the write in this state stores the updated dirs
          if (dirs == 4'd0) state <= S_BACK;
          else begin
            random_state <= lfsr_nx;
            dsel <= lfsr_nx[1:0];
            if (dirs[lfsr_nx[1:0]]) begin
              dirs[lfsr_nx[1:0]] <= 1'b0;
              unique case (lfsr_nx[1:0])
                gmb_pkg::DIR_RIGHT: begin nx <= cx + 6'd2; ny <= cy;
                  state <= (7'(cx) + 7'd2 >= 7'(w)) ? S_DRAW : S_CHK_RD; end
                gmb_pkg::DIR_DOWN: begin nx <= cx; ny <= cy + 6'd2;
                  state <= (7'(cy) + 7'd2 >= 7'(h)) ? S_DRAW : S_CHK_RD; end
                gmb_pkg::DIR_LEFT: begin nx <= cx - 6'd2; ny <= cy;
                  state <= (cx < 6'd2) ? S_DRAW : S_CHK_RD; end
                default: begin nx <= cx; ny <= cy - 6'd2;
                  state <= (cy < 6'd2) ? S_DRAW : S_CHK_RD; end
              endcase
            end
          end
        end
        S_CHK_RD: state <= S_CHK_WAIT;
        S_CHK_WAIT: state <= S_CHK;
        S_CHK: begin
          if (!row_rdata[nx] || nd_rdata[2:0] != gmb_pkg::BACK_NONE) state <= S_DRAW;
          else state <= S_CARVE_ROW;
        end
        S_CARVE_ROW: state <= S_CARVE_WR;
        S_CARVE_WR: begin
          cx <= nx; cy <= ny;
          state <= S_NODE_RD;
        end
        S_BACK: begin
          logic [5:0] bx, by;
          bx = cx; by = cy;
          unique case (back)
            gmb_pkg::BACK_RIGHT: bx = cx + 6'd2;
            gmb_pkg::BACK_DOWN:  by = cy + 6'd2;
            gmb_pkg::BACK_LEFT:  bx = cx - 6'd2;
            gmb_pkg::BACK_UP:    by = cy - 6'd2;
            default: begin bx = 6'd1; by = 6'd1; end
          endcase
          cx <= bx; cy <= by;
          if (bx == 6'd1 && by == 6'd1) begin
            iy <= '0; state <= S_OUT_RD;
          end else state <= S_NODE_RD;
        end
        S_OUT_RD: state <= S_OUT_WAIT;
        S_OUT_WAIT: begin
          row_valid <= 1'b1;
          row_index <= iy;
          row_cells <= row_rdata & ((63'(1) << w) - 63'(1));
          last_row <= (iy == h - 6'd1);
          state <= S_OUT;
        end
        S_OUT: if (row_ready) begin
          row_valid <= 1'b0;
          if (iy == h - 6'd1) state <= S_IDLE;
          else begin iy <= iy + 6'd1; state <= S_OUT_RD; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gmb_ram.sv
// ----------------------------------------------------------------------------
// gmb_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module gmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/gmb_checker.sv
// ----------------------------------------------------------------------------
// gmb_port_props: port-level checks for the maze backtracker
// Watches handshakes and that a stalled row keeps its index.
// ----------------------------------------------------------------------------
module gmb_port_props (
  input logic       clk,
  input logic       rst,
  input logic       seed_valid,
  input logic       seed_ready,
  input logic       row_valid,
  input logic       row_ready,
  input logic [5:0] row_index,
  input logic       last_row
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(seed_ready && row_valid)) else $error("seed ready while rows pending");

  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_ready |=> row_valid && $stable(row_index))
    else $error("row dropped while stalled");

  a_first_row: assert property (@(posedge clk) disable iff (rst)
    seed_valid && seed_ready |=> !row_valid) else $error("row too early");

  a_done: assert property (@(posedge clk) disable iff (rst)
    row_valid && row_ready && last_row |=> seed_ready)
    else $error("not idle after last row");
endmodule

bind grid_maze_backtracker_unit gmb_port_props u_gmb_port_props (
  .clk(clk), .rst(rst), .seed_valid(seed_valid), .seed_ready(seed_ready),
  .row_valid(row_valid), .row_ready(row_ready), .row_index(row_index),
  .last_row(last_row));

// File: tb/sv/gmb_checker.sv
// ----------------------------------------------------------------------------
// gmb_checker: row predictor and scoreboard for the maze backtracker
// Watches seed and row transactions, rebuilds each maze and checks every row.
// ----------------------------------------------------------------------------
module gmb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        seed_valid,
  input  logic        seed_ready,
  input  logic [31:0] seed,
  input  logic        row_valid,
  input  logic        row_ready,
  input  logic [5:0]  row_index,
  input  logic [62:0] row_cells,
  input  logic        last_row,
  output int          fail_count,
  output int          rows_pending
);

  typedef struct packed {
    logic [5:0]  index;
    logic [62:0] cells;
    logic        last;
  } maze_row_t;

  maze_row_t   row_queue[$];
  logic [5:0]  width_reg;
  logic [5:0]  height_reg;
  logic [15:0] thresh_reg;
  logic [31:0] lfsr;

  logic        open_map[4096];
  logic [3:0]  untried[1024];
  logic [2:0]  parent_dir[1024];

  function automatic logic [31:0] next_draw();
    logic lsb;
    lsb = lfsr[0];
    lfsr = lfsr >> 1;
    if (lsb) lfsr = lfsr ^ gmb_pkg::LFSR_MASK;
    return lfsr;
  endfunction

  function automatic int clamp_dim(logic [5:0] v, int maxv);
    int capv;
    int o;
    capv = ((maxv - 1) | 1) & 63;
    o = (v | 1) & 63;
    if (o < 3) o = 3;
    if (o > capv) o = capv;
    return o;
  endfunction

  function automatic int ci(int x, int y);
    return ((y & 63) << 6) | (x & 63);
  endfunction

  function automatic int ni(int x, int y);
    return (((y >> 1) & 31) << 5) | ((x >> 1) & 31);
  endfunction

  task automatic build_maze(logic [31:0] s);
    int w, h, cx, cy, nx, ny, n, wx, wy;
    logic [1:0] d;
    logic [3:0] bitm;
    logic moved, skip;
    logic [15:0] r;
    maze_row_t mr;
    w = clamp_dim(width_reg, gmb_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, gmb_pkg::MAX_HEIGHT_DEF);
    lfsr = (s == 0) ? 32'd1 : s;
    for (int i = 0; i < 4096; i++) open_map[i] = 1'b0;
    for (int i = 0; i < 1024; i++) begin
      untried[i] = '0;
      parent_dir[i] = gmb_pkg::BACK_NONE;
    end
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        r = 16'(next_draw());
        if ((x & y & 1) != 0) begin
          open_map[ci(x, y)] = 1'b1;
          untried[ni(x, y)] = gmb_pkg::ALL_DIRS;
        end
        if (r < thresh_reg && x != 0 && y != 0 && x != w - 1 && y != h - 1 &&
            !(x == 1 && y == 1) && !(x == w - 2 && y == h - 2))
          open_map[ci(x, y)] = 1'b1;
      end
    end
    wx = 1;
    wy = 1;
    parent_dir[ni(1, 1)] = gmb_pkg::BACK_START;
    forever begin
      cx = wx;
      cy = wy;
      n = ni(cx, cy);
      moved = 1'b0;
      while (untried[n] != 0 && !moved) begin
        d = 2'(next_draw());
        bitm = 4'b1 << d;
        nx = cx;
        ny = cy;
        skip = 1'b0;
        if ((untried[n] & bitm) != 0) begin
          untried[n] = untried[n] & ~bitm;
          case (d)
            gmb_pkg::DIR_RIGHT: if (cx + 2 >= w) skip = 1'b1; else nx = cx + 2;
            gmb_pkg::DIR_DOWN:  if (cy + 2 >= h) skip = 1'b1; else ny = cy + 2;
            gmb_pkg::DIR_LEFT:  if (cx < 2) skip = 1'b1; else nx = cx - 2;
            default:            if (cy < 2) skip = 1'b1; else ny = cy - 2;
          endcase
          if (!skip && open_map[ci(nx, ny)] &&
              parent_dir[ni(nx, ny)] == gmb_pkg::BACK_NONE) begin
            // back-pointer runs from child to parent
            parent_dir[ni(nx, ny)] = 3'(((d + 2) & 3) + 1);
            open_map[ci((cx + nx) >> 1, (cy + ny) >> 1)] = 1'b1;
            wx = nx;
            wy = ny;
            moved = 1'b1;
          end
        end
      end
      if (!moved) begin
        case (parent_dir[n])
          gmb_pkg::BACK_RIGHT: wx = cx + 2;
          gmb_pkg::BACK_DOWN:  wy = cy + 2;
          gmb_pkg::BACK_LEFT:  wx = cx - 2;
          gmb_pkg::BACK_UP:    wy = cy - 2;
          default: begin
            wx = 1;
            wy = 1;
          end
        endcase
      end
      if (wx == 1 && wy == 1) break;
    end
    for (int y = 0; y < h; y++) begin
      mr.index = 6'(y);
      mr.cells = '0;
      for (int x = 0; x < w; x++)
        if (open_map[ci(x, y)]) mr.cells[x] = 1'b1;
      mr.last = (y == h - 1);
      row_queue.push_back(mr);
    end
  endtask

  always @(posedge clk) begin
    maze_row_t exp_row;
    int errs;
    errs = 0;
    if (rst) begin
      width_reg    <= 6'd63;
      height_reg   <= 6'd63;
      thresh_reg   <= 16'd0;
      fail_count   <= 0;
      rows_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gmb_pkg::REG_WIDTH:     width_reg  <= cfg_data[5:0];
          gmb_pkg::REG_HEIGHT:    height_reg <= cfg_data[5:0];
          gmb_pkg::REG_THRESHOLD: thresh_reg <= cfg_data;
          default: ;
        endcase
      end
      if (seed_valid && seed_ready) build_maze(seed);
      if (row_valid && row_ready) begin
        if (row_queue.size() == 0) begin
          $error("row transaction with no maze pending: index %0d", row_index);
          errs++;
        end else begin
          exp_row = row_queue.pop_front();
          if (row_index !== exp_row.index) begin
            $error("row_index: expected %0d, actual %0d", exp_row.index, row_index);
            errs++;
          end
          if (row_cells !== exp_row.cells) begin
            $error("row_cells: expected %h, actual %h", exp_row.cells, row_cells);
            errs++;
          end
          if (last_row !== exp_row.last) begin
            $error("last_row: expected %0b, actual %0b", exp_row.last, last_row);
            errs++;
          end
        end
      end
      fail_count   <= fail_count + errs;
      rows_pending <= row_queue.size();
    end
  end
endmodule

// File: tb/sv/tb_grid_maze_backtracker_unit.sv
// ----------------------------------------------------------------------------
// tb_grid_maze_backtracker_unit: stimulus and verdict for the maze generator
// Sweeps sizes and thresholds, sends directed and random seeds with idling.
// ----------------------------------------------------------------------------
module tb_grid_maze_backtracker_unit;

  localparam int WATCHDOG_LIMIT = 500000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = gmb_pkg::REG_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        seed_valid = 1'b0;
  logic        seed_ready;
  logic [31:0] seed = '0;
  logic        row_valid;
  logic        row_ready = 1'b0;
  logic [5:0]  row_index;
  logic [62:0] row_cells;
  logic        last_row;
  int          fail_count;
  int          rows_pending;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_rows = 1'b0;
  logic        hold_done = 1'b0;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_maze_backtracker_unit i_dut (.*);

  gmb_checker i_checker (.*);

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      row_ready <= 1'b0;
    end else if (hold_rows) begin
      row_ready <= 1'b0;
    end else begin
      row_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
    end
  end

  initial begin
    wait (hold_req);
    hold_rows <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_rows <= 1'b0;
    hold_done <= 1'b1;
  end

  always @(posedge clk) begin
    if ((seed_valid && seed_ready) || (row_valid && row_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_maze(logic [31:0] s);
    while (!calm && $urandom_range(99) < 19) @(posedge clk);
    seed_valid <= 1'b1;
    seed       <= s;
    @(posedge clk);
    while (!seed_ready) @(posedge clk);
    seed_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (rows_pending != 0 || !seed_ready) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_shape(logic [15:0] w, logic [15:0] h, logic [15:0] t);
    drain();
    write_reg(gmb_pkg::REG_WIDTH, w);
    write_reg(gmb_pkg::REG_HEIGHT, h);
    write_reg(gmb_pkg::REG_THRESHOLD, t);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset defaults: full-size perfect maze
    send_maze(32'd0);
    set_shape(16'd3, 16'd3, 16'd0);       // single node
    send_maze(32'hFFFF_FFFF);
    set_shape(16'd0, 16'd1, 16'hFFFF);    // small dimensions clamp to three
    send_maze(32'h1234_5678);
    set_shape(16'd4, 16'd10, 16'hFFFF);   // even sizes forced odd
    send_maze(32'hA5A5_5A5A);
    send_maze(32'h5A5A_A5A5);
    set_shape(16'hFFFF, 16'd5, 16'h8000); // width field all ones, extra bits high
    send_maze(32'h8000_0001);
    set_shape(16'd63, 16'd63, 16'h4000);
    send_maze(32'h0000_0001);
    // long receiver hold-off while the sender keeps offering
    set_shape(16'd7, 16'd9, 16'd0);
    hold_req <= 1'b1;
    for (int i = 0; i < 6; i++) send_maze($urandom);
    wait (hold_done);
    // invalid index is ignored
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    calm <= 1'b1;
    for (int i = 0; i < 10; i++) send_maze($urandom);
    calm <= 1'b0;
    for (int i = 0; i < 85; i++) begin
      if (i % 12 == 0) begin
        if ($urandom_range(9) == 0)
          set_shape(16'($urandom_range(33, 63)), 16'($urandom_range(33, 63)),
                    16'($urandom));
        else
          set_shape(16'($urandom_range(0, 21)), 16'($urandom_range(0, 21)),
                    $urandom_range(1) ? 16'($urandom) : 16'd0);
      end
      send_maze($urandom);
    end
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
